>>> rtl/ltt_pkg.sv
// Shared types and constants for the LRU tag table.
// Depends on nothing; every other file in rtl/ imports it.
`default_nettype none

package ltt_pkg;

	// Port field widths of the request and response channels.
	localparam int ACTION_W = 2;
	localparam int KEY_TAG_W = 64;
	localparam int HANDLE_W = 32;

	// Action codes carried in the request.
	typedef enum logic [ACTION_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_LOOKUP = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_CLEAR  = 2'd3
	} act_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_CMP  = 2'd1,
		ST_GATH = 2'd2,
		ST_UPD  = 2'd3
	} state_t;

	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		logic cmp_en;
		logic upd_en;
		act_t act;
	} cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/ltt_req_if.sv
// Request channel of the LRU tag table: valid/ready handshake plus payload.
// Depends on ltt_pkg for the field widths.
`default_nettype none

interface ltt_req_if;
	import ltt_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [ACTION_W-1:0]  action;
	logic [KEY_TAG_W-1:0] key_tag;
	logic                 photo_given;
	logic [HANDLE_W-1:0]  photo_handle_in;

	modport source (output valid, action, key_tag, photo_given, photo_handle_in, input ready);
	modport sink   (input valid, action, key_tag, photo_given, photo_handle_in, output ready);
endinterface

`default_nettype wire

>>> rtl/ltt_rsp_if.sv
// Response channel of the LRU tag table: valid/ready handshake plus payload.
// Depends on ltt_pkg for the field widths.
`default_nettype none

interface ltt_rsp_if;
	import ltt_pkg::*;

	logic                valid;
	logic                ready;
	logic                hit;
	logic                photo_present;
	logic [HANDLE_W-1:0] photo_handle_out;
	logic                evicted;

	modport source (output valid, hit, photo_present, photo_handle_out, evicted, input ready);
	modport sink   (input valid, hit, photo_present, photo_handle_out, evicted, output ready);
endinterface

`default_nettype wire

>>> rtl/ltt_cell.sv
// One slot of the recency-ordered chain: holds an entry, compares it with the
// request key, and moves entries to and from its neighbors. Depends on ltt_pkg.
`default_nettype none

module ltt_cell #(
	parameter int KEY_BITS    = 64,
	parameter int HANDLE_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ltt_pkg::cell_ctl_t     ctl,
	input  logic [KEY_BITS-1:0]    req_key,
	// Entry of the more recent neighbor (or the new entry for the head cell).
	input  logic                   prev_valid,
	input  logic [KEY_BITS-1:0]    prev_key,
	input  logic                   prev_photo,
	input  logic [HANDLE_BITS-1:0] prev_handle,
	// Entry of the less recent neighbor (empty past the tail cell).
	input  logic                   next_valid,
	input  logic [KEY_BITS-1:0]    next_key,
	input  logic                   next_photo,
	input  logic [HANDLE_BITS-1:0] next_handle,
	// This cell's entry.
	output logic                   valid,
	output logic [KEY_BITS-1:0]    key,
	output logic                   photo,
	output logic [HANDLE_BITS-1:0] handle,
	output logic                   match,
	// Insert chain: set once a hit or an empty slot has been passed.
	input  logic                   hold_in,
	output logic                   hold_out,
	// Remove chain: set at and after the matching cell.
	input  logic                   pull_in,
	output logic                   pull_out,
	// Gather chain: ORs the matching entry's contents toward the tail.
	input  logic                   hit_in,
	output logic                   hit_out,
	input  logic                   photo_in,
	output logic                   photo_out,
	input  logic [HANDLE_BITS-1:0] handle_in,
	output logic [HANDLE_BITS-1:0] handle_out
);
	import ltt_pkg::*;

	logic                   valid_q;
	logic [KEY_BITS-1:0]    key_q;
	logic                   photo_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic                   match_q;
	logic                   take_prev;
	logic                   take_next;
	logic                   wipe;

	assign valid  = valid_q;
	assign key    = key_q;
	assign photo  = photo_q;
	assign handle = handle_q;
	assign match  = match_q;

	// Chain terms, all from registered state.
	assign hold_out   = hold_in | match_q | ~valid_q;
	assign pull_out   = pull_in | match_q;
	assign hit_out    = hit_in | match_q;
	assign photo_out  = photo_in | (match_q & photo_q);
	assign handle_out = handle_in | (match_q ? handle_q : '0);

	// Decide where this cell's next entry comes from.
	always_comb begin
		take_prev = ctl.upd_en && (ctl.act == ACT_INSERT) && !hold_in;
		take_next = ctl.upd_en && (ctl.act == ACT_REMOVE) && pull_out;
		wipe      = ctl.upd_en && (ctl.act == ACT_CLEAR);
	end

	// Valid bit and registered key compare.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctl.cmp_en) begin
				match_q <= valid_q && (key_q == req_key);
			end
			if (wipe) begin
				valid_q <= 1'b0;
			end else if (take_prev) begin
				valid_q <= prev_valid;
			end else if (take_next) begin
				valid_q <= next_valid;
			end
		end
	end

	// Entry payload; meaningful only while the valid bit is set.
	always_ff @(posedge clk) begin
		if (take_prev) begin
			key_q    <= prev_key;
			photo_q  <= prev_photo;
			handle_q <= prev_handle;
		end else if (take_next) begin
			key_q    <= next_key;
			photo_q  <= next_photo;
			handle_q <= next_handle;
		end
	end

endmodule

`default_nettype wire

>>> rtl/lru_tag_table.sv
// Top level of the LRU tag table: request sequencer, chain of cells, result register.
// Depends on ltt_pkg, ltt_req_if, ltt_rsp_if and ltt_cell.
`default_nettype none

// Channel  Role    Payload
// req      sink    action, key_tag, photo_given, photo_handle_in
// rsp      source  hit, photo_present, photo_handle_out, evicted
//
// Each request passes through four steps from acceptance to a loaded result:
// acceptance, the per-cell key compare, gathering the matching entry along the
// chain, and shifting the chain and loading the result register.
// Entries are kept packed in recency order, head cell most recent.
// A result waiting in the result register does not block the next request;
// only the update step waits for it to be taken.
// Reset empties the table at once and leaves no result pending.

module lru_tag_table #(
	parameter int CAPACITY    = 20,
	parameter int KEY_BITS    = 64,
	parameter int HANDLE_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	ltt_req_if.sink    req,
	ltt_rsp_if.source  rsp
);
	import ltt_pkg::*;

	state_t                 state_q;
	state_t                 state_d;
	cell_ctl_t              ctl;

	// Registered request.
	act_t                   act_q;
	logic [KEY_BITS-1:0]    rkey_q;
	logic                   given_q;
	logic [HANDLE_W-1:0]    rhandle_q;

	// Gathered contents of the matching entry.
	logic                   ghit_q;
	logic                   gphoto_q;
	logic [HANDLE_BITS-1:0] ghandle_q;

	// Result register.
	logic                   out_valid_q;
	logic                   out_hit_q;
	logic                   out_photo_q;
	logic [HANDLE_W-1:0]    out_handle_q;
	logic                   out_evicted_q;

	logic                   accept;
	logic                   upd_fire;
	logic                   evict_c;
	logic [63:0]            hin_wide;
	logic [63:0]            hout_wide;
	logic                   new_photo;
	logic [HANDLE_BITS-1:0] new_handle;

	// Chain wiring.
	logic                   cv  [CAPACITY];
	logic [KEY_BITS-1:0]    ck  [CAPACITY];
	logic                   cp  [CAPACITY];
	logic [HANDLE_BITS-1:0] ch  [CAPACITY];
	logic [CAPACITY-1:0]    valid_vec;
	logic [CAPACITY-1:0]    match_vec;
	logic [CAPACITY:0]      hold_c;
	logic [CAPACITY:0]      pull_c;
	logic [CAPACITY:0]      ghit_c;
	logic [CAPACITY:0]      gphoto_c;
	logic [HANDLE_BITS-1:0] ghandle_c [CAPACITY+1];

	assign accept   = req.valid && req.ready;
	assign upd_fire = ctl.upd_en;

	// Width adaptation of the handle between port and storage.
	assign hin_wide  = {32'd0, rhandle_q};
	assign hout_wide = 64'(ghandle_q);

	// Contents of the entry placed at the head on insert.
	assign new_photo  = given_q | gphoto_q;
	assign new_handle = given_q ? hin_wide[HANDLE_BITS-1:0] : ghandle_q;

	assign hold_c[0]    = 1'b0;
	assign pull_c[0]    = 1'b0;
	assign ghit_c[0]    = 1'b0;
	assign gphoto_c[0]  = 1'b0;
	assign ghandle_c[0] = '0;

	// The tail entry drops out when the whole chain shifts on insert.
	assign evict_c = (act_q == ACT_INSERT) && !hold_c[CAPACITY];

	// Row of cells, head first.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                   pv;
		logic [KEY_BITS-1:0]    pk;
		logic                   pp;
		logic [HANDLE_BITS-1:0] ph;
		logic                   nv;
		logic [KEY_BITS-1:0]    nk;
		logic                   np;
		logic [HANDLE_BITS-1:0] nh;

		if (i == 0) begin : g_head
			assign pv = 1'b1;
			assign pk = rkey_q;
			assign pp = new_photo;
			assign ph = new_handle;
		end else begin : g_body
			assign pv = cv[i-1];
			assign pk = ck[i-1];
			assign pp = cp[i-1];
			assign ph = ch[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign nv = 1'b0;
			assign nk = '0;
			assign np = 1'b0;
			assign nh = '0;
		end else begin : g_mid
			assign nv = cv[i+1];
			assign nk = ck[i+1];
			assign np = cp[i+1];
			assign nh = ch[i+1];
		end

		assign valid_vec[i] = cv[i];

		ltt_cell #(
			.KEY_BITS    (KEY_BITS),
			.HANDLE_BITS (HANDLE_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.req_key     (rkey_q),
			.prev_valid  (pv),
			.prev_key    (pk),
			.prev_photo  (pp),
			.prev_handle (ph),
			.next_valid  (nv),
			.next_key    (nk),
			.next_photo  (np),
			.next_handle (nh),
			.valid       (cv[i]),
			.key         (ck[i]),
			.photo       (cp[i]),
			.handle      (ch[i]),
			.match       (match_vec[i]),
			.hold_in     (hold_c[i]),
			.hold_out    (hold_c[i+1]),
			.pull_in     (pull_c[i]),
			.pull_out    (pull_c[i+1]),
			.hit_in      (ghit_c[i]),
			.hit_out     (ghit_c[i+1]),
			.photo_in    (gphoto_c[i]),
			.photo_out   (gphoto_c[i+1]),
			.handle_in   (ghandle_c[i]),
			.handle_out  (ghandle_c[i+1])
		);
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and cell control.
	always_comb begin
		state_d    = state_q;
		req.ready  = 1'b0;
		ctl.cmp_en = 1'b0;
		ctl.upd_en = 1'b0;
		ctl.act    = act_q;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				ctl.cmp_en = 1'b1;
				state_d    = ST_GATH;
			end
			ST_GATH: begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				if (!out_valid_q || rsp.ready) begin
					ctl.upd_en = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Request register.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q     <= act_t'(req.action);
			rkey_q    <= req.key_tag[KEY_BITS-1:0];
			given_q   <= req.photo_given;
			rhandle_q <= req.photo_handle_in;
		end
	end

	// Matching entry as seen at the end of the gather chain.
	always_ff @(posedge clk) begin
		if (state_q == ST_GATH) begin
			ghit_q    <= ghit_c[CAPACITY];
			gphoto_q  <= gphoto_c[CAPACITY];
			ghandle_q <= ghandle_c[CAPACITY];
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; fields without meaning for an action are zero.
	always_ff @(posedge clk) begin
		if (upd_fire) begin
			out_hit_q     <= (act_q != ACT_CLEAR) && ghit_q;
			out_photo_q   <= (act_q == ACT_LOOKUP) && gphoto_q;
			out_handle_q  <= ((act_q == ACT_LOOKUP) && gphoto_q) ? hout_wide[31:0] : '0;
			out_evicted_q <= evict_c;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.hit              = out_hit_q;
	assign rsp.photo_present    = out_photo_q;
	assign rsp.photo_handle_out = out_handle_q;
	assign rsp.evicted          = out_evicted_q;

	// Keys are unique, so at most one cell can match.
	a_match_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GATH) |-> $onehot0(match_vec))
		else $error("more than one cell matched the request key");

	// Valid entries stay packed at the head of the chain.
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec & (valid_vec + 1'b1)) == '0))
		else $error("valid entries are not contiguous from the head");

	// An eviction only happens on a full table.
	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_fire && evict_c) |-> (&valid_vec))
		else $error("eviction with a free slot in the table");

	// An accepted request moves straight into the compare step.
	a_accept_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_CMP))
		else $error("accepted request did not start its compare");

	// Clear leaves the table empty.
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_fire && (act_q == ACT_CLEAR)) |=> (valid_vec == '0))
		else $error("clear left valid entries");

endmodule

`default_nettype wire
